// ===== rtl/dsds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_pkg: shared types and constants
// request and result layouts, policy codes, controller state and the
// command/status bundles between controller and datapath
// ----------------------------------------------------------------------------
package dsds_pkg;

  localparam int MAX_REQUESTS_DEF = 32;
  localparam int CYL_BITS_DEF     = 16;
  localparam int SEEK_W           = 24;
  localparam logic [SEEK_W-1:0] SEEK_MAX = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD      = 2'd2;

  typedef enum logic [2:0] {
    POL_FCFS  = 3'd0,
    POL_SSTF  = 3'd1,
    POL_SCAN  = 3'd2,
    POL_LOOK  = 3'd3,
    POL_CSCAN = 3'd4,
    POL_CLOOK = 3'd5
  } policy_t;

  typedef struct packed {
    logic [15:0] request_cylinder;
    logic        last;
  } in_req_t;

  typedef struct packed {
    logic [SEEK_W-1:0] total_seek;
    logic              overflow;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_EVAL,
    ST_PASS_END,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic begin_job;
    logic rd_en;
    logic eval;
    logic next_idx;
    logic pass_end;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_idx;
    logic last_pass;
    logic is_sstf;
  } status_t;

endpackage

// ===== rtl/dsds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_ctrl: job sequencer
// walks the stored requests once per pass and issues datapath commands
// ----------------------------------------------------------------------------
module dsds_ctrl
  import dsds_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    job_end,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (job_end) state_nxt = ST_START;
      end
      ST_START: begin
        cmd.begin_job = 1'b1;
        state_nxt     = ST_RD;
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (!stat.last_idx) begin
          cmd.next_idx = 1'b1;
          state_nxt    = ST_RD;
        end else if (stat.is_sstf) begin
          state_nxt = ST_PASS_END;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_PASS_END: begin
        cmd.pass_end = 1'b1;
        state_nxt    = stat.last_pass ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/dsds_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_dp: request store and seek arithmetic
// holds configuration, the request memory, served marks and accumulators
// ----------------------------------------------------------------------------
module dsds_dp
  import dsds_pkg::*;
#(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
  parameter int CYL_BITS     = CYL_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  accept,
  input  in_req_t               in_req,
  input  cmd_t                  cmd,
  output status_t               stat,
  output logic                  out_valid,
  output out_res_t              out_res
);

  localparam int AW   = $clog2(MAX_REQUESTS);
  localparam int CNTW = $clog2(MAX_REQUESTS + 1);
  localparam int CW   = CYL_BITS;
  localparam int TW   = 17;
  localparam int SW   = ((CW > TW) ? CW : TW) + 3;
  localparam int ACW  = ((CW > SEEK_W) ? CW : SEEK_W) + 1;

  // configuration
  logic [2:0]    policy_r;
  logic [TW-1:0] cyl_count_r;
  logic [15:0]   head_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POL_FCFS;
      cyl_count_r  <= TW'(200);
      head_start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:    policy_r     <= cfg_wdata[2:0];
        CFG_CYL_COUNT: cyl_count_r  <= cfg_wdata;
        CFG_HEAD:      head_start_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // walk state
  logic [AW-1:0]     idx_r;
  logic [CNTW-1:0]   pass_r;
  logic [CW-1:0]     head_r;
  logic [ACW-1:0]    acc_r;
  logic              found_r;
  logic [CW-1:0]     bestd_r;
  logic [AW-1:0]     best_r;
  logic [CW-1:0]     bestv_r;
  logic [CW-1:0]     lo_r, hia_r, loa_r;
  logic              above_r;
  logic [MAX_REQUESTS-1:0] served_r;

  // request store
  logic [CW-1:0]   mem [MAX_REQUESTS];
  logic [CW-1:0]   rdata_r;
  logic [CNTW-1:0] cnt_r;
  logic            ovf_r;
  logic            full;

  assign full = (cnt_r == CNTW'(MAX_REQUESTS));

  always_ff @(posedge clk) begin
    if (accept && !full) mem[cnt_r[AW-1:0]] <= CW'(in_req.request_cylinder);
    if (cmd.rd_en) rdata_r <= mem[idx_r];
  end

  logic [CW-1:0]  d;
  logic [ACW-1:0] acc_add, acc_sat;

  assign d       = (rdata_r > head_r) ? rdata_r - head_r : head_r - rdata_r;
  assign acc_add = acc_r + ACW'(cmd.pass_end ? bestd_r : d);
  assign acc_sat = (acc_add > ACW'(SEEK_MAX)) ? ACW'(SEEK_MAX) : acc_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      served_r <= '0;
    end else begin
      if (accept) begin
        if (full) ovf_r <= 1'b1;
        else      cnt_r <= cnt_r + CNTW'(1);
      end
      if (cmd.pass_end) served_r[best_r] <= 1'b1;
      if (cmd.finish) begin
        cnt_r    <= '0;
        ovf_r    <= 1'b0;
        served_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_job) begin
      idx_r   <= '0;
      pass_r  <= '0;
      head_r  <= CW'(head_start_r);
      lo_r    <= CW'(head_start_r);
      acc_r   <= '0;
      found_r <= 1'b0;
      above_r <= 1'b0;
    end
    if (cmd.next_idx) idx_r <= idx_r + AW'(1);
    if (cmd.eval) begin
      case (policy_r)
        POL_FCFS: begin
          acc_r  <= acc_sat;
          head_r <= rdata_r;
        end
        POL_SSTF: begin
          if (!served_r[idx_r] && (!found_r || d < bestd_r)) begin
            found_r <= 1'b1;
            bestd_r <= d;
            best_r  <= idx_r;
            bestv_r <= rdata_r;
          end
        end
        default: begin
          if (rdata_r < lo_r) lo_r <= rdata_r;
          if (rdata_r > head_r) begin
            if (!above_r || rdata_r > hia_r) hia_r <= rdata_r;
            if (!above_r || rdata_r < loa_r) loa_r <= rdata_r;
            above_r <= 1'b1;
          end
        end
      endcase
    end
    if (cmd.pass_end) begin
      acc_r   <= acc_sat;
      head_r  <= bestv_r;
      found_r <= 1'b0;
      idx_r   <= '0;
      pass_r  <= pass_r + CNTW'(1);
    end
  end

  assign stat.last_idx  = ((CNTW'(idx_r) + CNTW'(1)) == cnt_r);
  assign stat.last_pass = ((pass_r + CNTW'(1)) == cnt_r);
  assign stat.is_sstf   = (policy_r == POL_SSTF);

  // sweep totals
  logic [TW-1:0] top;
  logic [SW-1:0] hd, lo, hia, loa, tp, dtop, sweep, sw_sat;
  logic [SEEK_W-1:0] total;

  assign top  = (cyl_count_r != '0) ? cyl_count_r - TW'(1) : '0;
  assign hd   = SW'(head_r);
  assign lo   = SW'(lo_r);
  assign hia  = SW'(hia_r);
  assign loa  = SW'(loa_r);
  assign tp   = SW'(top);
  assign dtop = (tp > hia) ? tp - hia : hia - tp;

  always_comb begin
    case (policy_r)
      POL_SCAN:  sweep = hd + (above_r ? hia : '0);
      POL_LOOK:  sweep = (hd - lo) + (above_r ? hia - lo : '0);
      POL_CSCAN: sweep = hd + tp + (above_r ? dtop + (hia - loa) : '0);
      default:   sweep = (hd - lo) + (above_r ? (hia - lo) + (hia - loa) : '0);
    endcase
  end

  assign sw_sat = (sweep > SW'(SEEK_MAX)) ? SW'(SEEK_MAX) : sweep;

  always_comb begin
    case (policy_r)
      POL_FCFS, POL_SSTF:                       total = acc_r[SEEK_W-1:0];
      POL_SCAN, POL_LOOK, POL_CSCAN, POL_CLOOK: total = sw_sat[SEEK_W-1:0];
      default:                                  total = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
    if (cmd.finish) begin
      out_res.total_seek <= total;
      out_res.overflow   <= ovf_r;
    end
  end

endmodule

// ===== rtl/disk_seek_distance_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_seek_distance_scheduler_core: total head travel of a request job
// stores cylinder requests and reports seek distance under fcfs, sstf,
// scan, look, c-scan or c-look
// ----------------------------------------------------------------------------
// requests load one per cycle while busy is low; a request with last set
// closes the job and raises busy while the stored requests are walked from
// the request memory, each entry addressed, then evaluated.
// fcfs and the sweep policies walk the stored requests once; sstf needs one
// full nearest-search pass per request served.
// out_valid is high for exactly one cycle and the result is not held: the
// receiver must take it on that cycle. write configuration only while idle.
module disk_seek_distance_scheduler_core
  import dsds_pkg::*;
#(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
  parameter int CYL_BITS     = CYL_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  in_req_t               in_req,
  // result channel
  output logic                  out_valid,
  output out_res_t              out_res
);

  cmd_t    cmd;
  status_t stat;
  logic    accept;

  // a request is taken only between jobs
  assign accept = start && !busy;

  dsds_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .job_end (accept && in_req.last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  dsds_dp #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .CYL_BITS     (CYL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: seek distance scheduler testbench
// feeds request jobs under every policy and several geometries, predicts the
// total head travel of each job and checks every result strobe against it
// ----------------------------------------------------------------------------
module tb;
  import dsds_pkg::*;

  localparam int STORE_DEPTH = 32;
  localparam int STALL_LIMIT = 20000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_POLICY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start = 1'b0;
  logic                  busy;
  in_req_t               in_req = '0;
  logic                  out_valid;
  out_res_t              out_res;

  disk_seek_distance_scheduler_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor copy of the block state and registers
  logic [2:0]  mode_q = POL_FCFS;
  logic [16:0] cyl_count_q = 17'd200;
  logic [15:0] head_q = '0;
  logic [15:0] job_cyl [STORE_DEPTH];
  int          job_len = 0;
  bit          job_ovf = 1'b0;

  in_req_t  pending_reqs[$];
  out_res_t expected_seeks[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       sender_gaps = 1'b1;
  int       gap_left = 0;

  function automatic longint unsigned leg(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // total travel of the stored job under the current policy
  function automatic longint unsigned job_travel();
    longint unsigned sum = 0, pos = head_q, lo = head_q, hia = 0, loa = 0, top, d, bestd;
    bit above = 0, found;
    bit taken [STORE_DEPTH];
    int best;
    top = (cyl_count_q > 0) ? cyl_count_q - 1 : 0;
    for (int i = 0; i < STORE_DEPTH; i++) taken[i] = 0;
    case (mode_q)
      POL_FCFS: begin
        for (int i = 0; i < job_len; i++) begin
          sum += leg(job_cyl[i], pos);
          pos = job_cyl[i];
        end
      end
      POL_SSTF: begin
        // nearest untaken, strict minimum keeps the earliest on ties
        for (int k = 0; k < job_len; k++) begin
          found = 0; best = 0; bestd = 0;
          for (int i = 0; i < job_len; i++) begin
            if (!taken[i]) begin
              d = leg(job_cyl[i], pos);
              if (!found || d < bestd) begin
                found = 1; bestd = d; best = i;
              end
            end
          end
          taken[best] = 1;
          sum += bestd;
          pos = job_cyl[best];
        end
      end
      POL_SCAN, POL_LOOK, POL_CSCAN, POL_CLOOK: begin
        for (int i = 0; i < job_len; i++) begin
          if (job_cyl[i] < lo) lo = job_cyl[i];
          if (job_cyl[i] > pos) begin
            if (!above || job_cyl[i] > hia) hia = job_cyl[i];
            if (!above || job_cyl[i] < loa) loa = job_cyl[i];
            above = 1;
          end
        end
        case (mode_q)
          POL_SCAN:  sum = pos + (above ? hia : 0);
          POL_LOOK:  sum = (pos - lo) + (above ? hia - lo : 0);
          POL_CSCAN: sum = pos + top + (above ? leg(top, hia) + (hia - loa) : 0);
          default:   sum = (pos - lo) + (above ? (hia - lo) + (hia - loa) : 0);
        endcase
      end
      default: sum = 0;
    endcase
    return sum;
  endfunction

  task automatic take_request(in_req_t r);
    out_res_t e;
    longint unsigned t;
    if (job_len < STORE_DEPTH) begin
      job_cyl[job_len] = r.request_cylinder;
      job_len++;
    end else begin
      job_ovf = 1'b1;
    end
    if (r.last) begin
      t = job_travel();
      e.total_seek = (t > SEEK_MAX) ? SEEK_MAX : SEEK_W'(t);
      e.overflow = job_ovf;
      expected_seeks.push_back(e);
      job_len = 0;
      job_ovf = 1'b0;
    end
  endtask

  // driver: one request per accept, optional random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        take_request(in_req);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_req <= pending_reqs.pop_front();
          start <= 1'b1;
          gap_left <= sender_gaps ? $urandom_range(0, 16) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, take each strobe as it comes
  always @(posedge clk) begin
    out_res_t e;
    if (rst_n && out_valid) begin
      if (expected_seeks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result seek=%0d ovf=%0d", out_res.total_seek, out_res.overflow);
      end else begin
        e = expected_seeks.pop_front();
        if (e.total_seek !== out_res.total_seek || e.overflow !== out_res.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp seek=%0d ovf=%0d, got seek=%0d ovf=%0d",
                     e.total_seek, e.overflow, out_res.total_seek, out_res.overflow);
        end
      end
    end
  end

  // watchdog on cycles with no request or result accepted
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POLICY:    mode_q = val[2:0];
      CFG_CYL_COUNT: cyl_count_q = val[16:0];
      default:       head_q = val[15:0];
    endcase
  endtask

  // block is idle once all requests are in and every result has come
  task automatic drain();
    do @(posedge clk); while (pending_reqs.size() > 0 || start || expected_seeks.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_geometry(logic [2:0] m, logic [16:0] cnt, logic [15:0] hd);
    drain();
    write_reg(CFG_POLICY, CFG_DATA_W'(m));
    write_reg(CFG_CYL_COUNT, cnt);
    write_reg(CFG_HEAD, CFG_DATA_W'(hd));
  endtask

  task automatic push_req(logic [15:0] c, bit lst);
    in_req_t r;
    r.request_cylinder = c;
    r.last = lst;
    pending_reqs.push_back(r);
  endtask

  // job with random cylinders, mostly within the disk, sometimes anywhere, at an extreme or at the head
  task automatic push_job(int n, ref int sent);
    logic [15:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       c = 16'($urandom());
        1:       c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        2:       c = head_q;
        default: c = (cyl_count_q == 0) ? 16'd0 :
                     (cyl_count_q > 65536) ? 16'($urandom()) :
                     16'($urandom_range(0, cyl_count_q - 1));
      endcase
      push_req(c, i == n - 1);
    end
    sent += n;
  endtask

  initial begin
    int sent;
    int jn;
    logic [16:0] cnt;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every policy, including the unknown codes, on a small job
    // with requests on both sides of the head
    for (int m = 0; m < 8; m++) begin
      set_geometry(m[2:0], 17'd200, 16'd80);
      push_req(16'd120, 0); push_req(16'd40, 0); push_req(16'd80, 1);
    end
    // nothing above the head, lone request, head at the extremes
    set_geometry(POL_CSCAN, 17'd65536, 16'hFFFF);
    push_req(16'd0, 1);
    set_geometry(POL_CLOOK, 17'd0, 16'd0);
    push_req(16'hFFFF, 0); push_req(16'd0, 1);
    // store overflow with a dropped last request
    set_geometry(POL_FCFS, 17'h1FFFF, 16'd0);
    for (int i = 0; i < 34; i++) push_req(i[0] ? 16'hFFFF : 16'h0000, i == 33);

    // random phases over settings, extremes mixed in
    while (sent < 1400) begin
      case ($urandom_range(0, 5))
        0:       cnt = 17'd0;
        1:       cnt = 17'd1;
        2:       cnt = 17'd65536;
        3:       cnt = 17'($urandom_range(0, 17'h1FFFF));
        default: cnt = 17'($urandom_range(2, 1000));
      endcase
      set_geometry(3'($urandom_range(0, 7)), cnt,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                   (cnt == 0) ? 16'd0 : 16'($urandom_range(0, (cnt > 65536) ? 65535 : cnt - 1)));
      sender_gaps = $urandom_range(0, 3) != 0;
      for (int j = 0; j < 12; j++) begin
        jn = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        push_job(jn, sent);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_seeks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
